// ===== design/tga_rle_pkg.sv =====
package tga_rle_pkg;

    localparam int DEFAULT_MAX_SIDE = 4096;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam logic [2:0] PIXEL_BYTES_RGBA = 3'd4;
    localparam logic [1:0] LAST_INDEX_RGBA  = 2'd3;
    localparam logic [1:0] LAST_INDEX_RGB   = 2'd2;

    localparam int TDATA_W = 40;

    typedef struct packed {
        logic       format_error;
        logic       last_pixel;
        logic [7:0] repeat_count;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

endpackage

// ===== design/tga_rle_pixel_decoder.sv =====
// Targa pixel-data decoder. Software parses the file header and programs
// rle_mode, pixel_bytes, image_width and image_height through the write port;
// any write restarts the image. The block then takes one pixel-data byte per
// s_ beat, in file order, and emits one beat per decoded pixel with blue and
// red swapped into RGB order and a repeat count (run length for a run packet,
// one otherwise, clamped to the pixels left). A byte is taken every cycle
// that s_tready is high: each byte is decoded by one pass of logic straight
// into an output register backed by a one-entry skid register, so s_tready
// drops only when both are full. m_tlast marks the beat that completes the
// image; m_tuser is the sticky error that a packet ran past the image end.
// Bytes after the last pixel are dropped. A configuration write reloads the
// pixel count with the product of the clamped sides in the same cycle.
module tga_rle_pixel_decoder #(
    parameter int MAX_SIDE = tga_rle_pkg::DEFAULT_MAX_SIDE
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // in_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // red, green, blue, alpha, repeat_count
    output logic [tga_rle_pkg::TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,   // last_pixel
    output logic                               m_tuser    // format_error
);
    import tga_rle_pkg::*;

    localparam int SIDE_CAP = (MAX_SIDE < (2**CFG_DATA_W) - 1) ? MAX_SIDE
                                                               : (2**CFG_DATA_W) - 1;
    localparam int SIDE_W   = $clog2(SIDE_CAP + 1);
    localparam int COUNT_W  = 2 * SIDE_W;
    localparam int CMP_W    = (COUNT_W > 8) ? COUNT_W : 8;

    function automatic logic [SIDE_W-1:0] side_of(input logic [CFG_DATA_W-1:0] v);
        logic [SIDE_W-1:0] s;
        if (v == '0) begin
            s = SIDE_W'(1);
        end else if (v > CFG_DATA_W'(SIDE_CAP)) begin
            s = SIDE_W'(SIDE_CAP);
        end else begin
            s = SIDE_W'(v);
        end
        return s;
    endfunction

    logic                  rle_mode_reg, rle_mode_next;
    logic [2:0]            pixel_bytes_reg, pixel_bytes_next;
    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;

    logic                  expect_hdr_reg, expect_hdr_next;
    logic                  is_run_reg, is_run_next;
    logic [7:0]            left_reg, left_next;
    logic [1:0]            bip_reg, bip_next;
    logic [7:0]            held_reg [3];
    logic [COUNT_W-1:0]    remain_reg, remain_next;
    logic                  error_reg, error_next;

    pixel_t                out_reg, out_next, skid_reg, skid_next, result;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;

    logic                  accept, active, produce, held_we;
    logic [1:0]            last_index;
    logic [7:0]            count, repeat_raw;
    logic [COUNT_W-1:0]    remain_after;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign active   = accept && (remain_reg != '0);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.repeat_count, out_reg.alpha, out_reg.blue,
                       out_reg.green, out_reg.red};
    assign m_tlast  = out_reg.last_pixel;
    assign m_tuser  = out_reg.format_error;

    assign last_index = (pixel_bytes_reg == PIXEL_BYTES_RGBA) ? LAST_INDEX_RGBA
                                                              : LAST_INDEX_RGB;

    always_comb begin
        rle_mode_next    = rle_mode_reg;
        pixel_bytes_next = pixel_bytes_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        expect_hdr_next  = expect_hdr_reg;
        is_run_next      = is_run_reg;
        left_next        = left_reg;
        bip_next         = bip_reg;
        remain_next      = remain_reg;
        error_next       = error_reg;
        produce          = 1'b0;
        held_we          = 1'b0;
        count            = {1'b0, s_tdata[6:0]} + 8'd1;
        repeat_raw       = 8'd1;
        remain_after     = remain_reg;
        result           = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RLE_MODE:     rle_mode_next    = cfg_data[0];
                CFG_PIXEL_BYTES:  pixel_bytes_next = cfg_data[2:0];
                CFG_IMAGE_WIDTH:  width_next       = cfg_data;
                CFG_IMAGE_HEIGHT: height_next      = cfg_data;
                default:          rle_mode_next    = rle_mode_reg;
            endcase
            expect_hdr_next = 1'b1;
            is_run_next     = 1'b0;
            left_next       = '0;
            bip_next        = '0;
            error_next      = 1'b0;
            remain_next     = COUNT_W'(side_of(width_next) * side_of(height_next));
        end else if (active) begin
            if (rle_mode_reg && expect_hdr_reg) begin
                if (CMP_W'(count) > CMP_W'(remain_reg)) begin
                    error_next = 1'b1;
                    count      = 8'(remain_reg);
                end
                is_run_next     = s_tdata[7];
                left_next       = count;
                bip_next        = '0;
                expect_hdr_next = 1'b0;
            end else if (bip_reg < last_index) begin
                held_we  = 1'b1;
                bip_next = bip_reg + 2'd1;
            end else begin
                bip_next = '0;
                if (!rle_mode_reg) begin
                    repeat_raw = 8'd1;
                end else if (is_run_reg) begin
                    repeat_raw      = left_reg;
                    left_next       = '0;
                    expect_hdr_next = 1'b1;
                end else begin
                    repeat_raw = 8'd1;
                    left_next  = left_reg - 8'd1;
                    if (left_next == '0) begin
                        expect_hdr_next = 1'b1;
                    end
                end
                if (CMP_W'(repeat_raw) > CMP_W'(remain_reg)) begin
                    repeat_raw = 8'(remain_reg);
                end
                remain_after = remain_reg - COUNT_W'(repeat_raw);
                remain_next  = remain_after;
                produce      = 1'b1;

                result.blue         = held_reg[0];
                result.green        = held_reg[1];
                result.red          = (last_index == LAST_INDEX_RGBA) ? held_reg[2] : s_tdata;
                result.alpha        = (last_index == LAST_INDEX_RGBA) ? s_tdata : 8'd0;
                result.repeat_count = repeat_raw;
                result.last_pixel   = (remain_after == '0);
                result.format_error = error_reg;
            end
        end
    end

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = result;
                out_valid_next = produce;
            end
        end else if (produce) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle_mode_reg    <= 1'b1;
            pixel_bytes_reg <= 3'd3;
            width_reg       <= CFG_DATA_W'(1);
            height_reg      <= CFG_DATA_W'(1);
            expect_hdr_reg  <= 1'b1;
            is_run_reg      <= 1'b0;
            left_reg        <= '0;
            bip_reg         <= '0;
            remain_reg      <= COUNT_W'(1);
            error_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            rle_mode_reg    <= rle_mode_next;
            pixel_bytes_reg <= pixel_bytes_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            expect_hdr_reg  <= expect_hdr_next;
            is_run_reg      <= is_run_next;
            left_reg        <= left_next;
            bip_reg         <= bip_next;
            remain_reg      <= remain_next;
            error_reg       <= error_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
        if (held_we) begin
            held_reg[bip_reg] <= s_tdata;
        end
    end

endmodule

// ===== design/tga_rle_checker.sv =====
module tga_rle_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_wr_en,
    input logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [7:0]                         s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tga_rle_pkg::TDATA_W-1:0]    m_tdata,
    input logic                               m_tlast,
    input logic                               m_tuser
);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_repeat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128))
        else $error("repeat count out of range");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output pending");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the output side");

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_tga_rle_checker (.*);
